/* rtl/core/abm_pkg.sv */
package abm_pkg;

    localparam int LEVEL_W   = 16;
    localparam int SQ_W      = 32;
    localparam int CHUNK_W   = 40;
    localparam int CLEN_W    = 16;
    localparam int BLEN_W    = 20;
    localparam int ENERGY_W  = 52;
    localparam int DIFF_W    = 17;
    localparam int DELTA_W   = 56;
    localparam int TOTAL_W   = 40;
    localparam int NCH_W     = 2;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int NUM_LANES = 2;
    localparam int NUM_SLOTS = 4;

    localparam logic [NCH_W-1:0]  NCH_STEREO  = 2'd2;
    localparam logic [NCH_W-1:0]  NCH_RESET   = 2'd2;
    localparam logic [CLEN_W-1:0] CLEN_RESET  = 16'd11025;
    localparam logic [BLEN_W-1:0] BLEN_RESET  = 20'd132300;

    localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [1:0] REG_CHUNK_LENGTH = 2'd1;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd2;

    localparam int SLOT_CHUNK   = 0;
    localparam int SLOT_BLOCK0  = 1;
    localparam int SLOT_BLOCK1  = 2;
    localparam int SLOT_SUMMARY = 3;

    typedef enum logic [1:0] {
        KIND_CHUNK   = 2'd0,
        KIND_BLOCK   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef struct packed {
        logic              stereo;
        logic [CLEN_W-1:0] clen;
        logic [BLEN_W-1:0] blen;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic adv;
        logic use_lane;
        logic clear;
    } t_lane_ctl;

    typedef struct packed {
        logic [LEVEL_W-1:0]  peak;
        logic [ENERGY_W-1:0] energy;
    } t_lane_stat;

    typedef struct packed {
        t_kind               kind;
        logic                channel;
        logic [CHUNK_W-1:0]  chunk_sum;
        logic [LEVEL_W-1:0]  peak;
        logic [ENERGY_W-1:0] energy;
        logic [BLEN_W-1:0]   frames_in_block;
        logic [DELTA_W-1:0]  delta_sum;
        logic [TOTAL_W-1:0]  total_frames;
        logic                last;
    } t_result;

endpackage

/* rtl/core/abm_if.sv */
interface abm_frame_if;
    import abm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [LEVEL_W-1:0] sample_ch0;
    logic signed [LEVEL_W-1:0] sample_ch1;
    logic                     end_of_stream;

    modport source (output valid, sample_ch0, sample_ch1, end_of_stream, input ready);
    modport sink   (input valid, sample_ch0, sample_ch1, end_of_stream, output ready);
endinterface

interface abm_result_if;
    import abm_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic                channel;
    logic [CHUNK_W-1:0]  chunk_sum;
    logic [LEVEL_W-1:0]  peak;
    logic [ENERGY_W-1:0] energy;
    logic [BLEN_W-1:0]   frames_in_block;
    logic [DELTA_W-1:0]  delta_sum;
    logic [TOTAL_W-1:0]  total_frames;
    logic                last;

    modport source (output valid, kind, channel, chunk_sum, peak, energy, frames_in_block,
                    delta_sum, total_frames, last, input ready);
    modport sink   (input valid, kind, channel, chunk_sum, peak, energy, frames_in_block,
                    delta_sum, total_frames, last, output ready);
endinterface

/* rtl/core/abm_lane.sv */
module abm_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [abm_pkg::LEVEL_W-1:0] i_sample,
    input  abm_pkg::t_lane_ctl                i_ctl,
    output logic [abm_pkg::LEVEL_W-1:0]       o_level,
    output abm_pkg::t_lane_stat               o_stat
);
    import abm_pkg::*;

    logic [LEVEL_W-1:0]  r_level;
    logic [SQ_W-1:0]     r_sq;
    logic [LEVEL_W-1:0]  r_peak;
    logic [ENERGY_W-1:0] r_energy;
    logic [LEVEL_W-1:0]  n_level;
    logic [LEVEL_W-1:0]  n_peak;
    logic [ENERGY_W-1:0] n_energy;
    logic [ENERGY_W:0]   energy_sum;

    // |2s+1| is the one's complement magnitude with a trailing one
    assign n_level = {(i_sample[LEVEL_W-1] ? ~i_sample[LEVEL_W-2:0] : i_sample[LEVEL_W-2:0]),
                      1'b1};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_level <= n_level;
            r_sq    <= SQ_W'(n_level) * SQ_W'(n_level);
        end
    end

    assign energy_sum = {1'b0, r_energy} + (ENERGY_W + 1)'(r_sq);

    always_comb begin
        if (i_ctl.use_lane) begin
            n_peak   = (r_level > r_peak) ? r_level : r_peak;
            n_energy = energy_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_sum[ENERGY_W-1:0];
        end else begin
            n_peak   = r_peak;
            n_energy = r_energy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak   <= '0;
            r_energy <= '0;
        end else if (i_ctl.adv) begin
            r_peak   <= i_ctl.clear ? '0 : n_peak;
            r_energy <= i_ctl.clear ? '0 : n_energy;
        end
    end

    assign o_level       = r_level;
    assign o_stat.peak   = n_peak;
    assign o_stat.energy = n_energy;

endmodule

/* rtl/core/abm_merge.sv */
module abm_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  abm_pkg::t_cfg                      i_cfg,
    input  logic signed [abm_pkg::LEVEL_W-1:0] i_sample0,
    input  logic signed [abm_pkg::LEVEL_W-1:0] i_sample1,
    input  logic                               i_load,
    input  logic                               i_adv,
    input  logic                               i_eos,
    input  logic [abm_pkg::LEVEL_W-1:0]        i_level0,
    input  logic [abm_pkg::LEVEL_W-1:0]        i_level1,
    input  abm_pkg::t_lane_stat                i_stat0,
    input  abm_pkg::t_lane_stat                i_stat1,
    input  logic                               i_ready,
    output logic                               o_block_done,
    output logic                               o_free,
    output logic                               o_valid,
    output abm_pkg::t_result                   o_result
);
    import abm_pkg::*;

    logic [DIFF_W-1:0]    r_diff;
    logic [CHUNK_W-1:0]   r_chunk;
    logic [CLEN_W-1:0]    r_ccnt;
    logic [BLEN_W-1:0]    r_bcnt;
    logic [DELTA_W-1:0]   r_delta;
    logic [TOTAL_W-1:0]   r_total;
    logic [NUM_SLOTS-1:0] r_pend;

    logic [CHUNK_W-1:0]   r_b_chunk;
    t_lane_stat           r_b_stat0;
    t_lane_stat           r_b_stat1;
    logic [BLEN_W-1:0]    r_b_fib;
    logic [DELTA_W-1:0]   r_b_delta;
    logic [TOTAL_W-1:0]   r_b_total;

    logic signed [LEVEL_W:0] diff_s;
    logic [LEVEL_W:0]        diff_mag;
    logic [CHUNK_W:0]        chunk_sum;
    logic [CHUNK_W-1:0]      n_chunk;
    logic [CLEN_W:0]         ccnt_inc;
    logic                    chunk_done;
    logic [BLEN_W:0]         bcnt_inc;
    logic [DELTA_W:0]        delta_sum;
    logic [DELTA_W-1:0]      n_delta;
    logic [TOTAL_W:0]        total_sum;
    logic [TOTAL_W-1:0]      n_total;
    logic [NUM_SLOTS-1:0]    n_pend;
    logic [NUM_SLOTS-1:0]    pend_rest;
    logic                    fire;

    assign diff_s   = (LEVEL_W + 1)'(i_sample0) - (LEVEL_W + 1)'(i_sample1);
    assign diff_mag = diff_s[LEVEL_W] ? (LEVEL_W + 1)'(-diff_s) : diff_s;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= {diff_mag[LEVEL_W-1:0], 1'b0};
        end
    end

    assign chunk_sum  = {1'b0, r_chunk} + (CHUNK_W + 1)'(i_level0)
                        + (i_cfg.stereo ? (CHUNK_W + 1)'(i_level1) : '0);
    assign n_chunk    = chunk_sum[CHUNK_W] ? {CHUNK_W{1'b1}} : chunk_sum[CHUNK_W-1:0];
    assign ccnt_inc   = {1'b0, r_ccnt} + 1'b1;
    assign chunk_done = ccnt_inc >= {1'b0, i_cfg.clen};

    assign bcnt_inc     = {1'b0, r_bcnt} + 1'b1;
    assign o_block_done = (bcnt_inc >= {1'b0, i_cfg.blen}) || i_eos;

    assign delta_sum = {1'b0, r_delta} + (i_cfg.stereo ? (DELTA_W + 1)'(r_diff) : '0);
    assign n_delta   = delta_sum[DELTA_W] ? {DELTA_W{1'b1}} : delta_sum[DELTA_W-1:0];
    assign total_sum = {1'b0, r_total} + 1'b1;
    assign n_total   = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
            r_ccnt  <= '0;
            r_bcnt  <= '0;
            r_delta <= '0;
            r_total <= '0;
        end else if (i_adv) begin
            r_chunk <= (chunk_done || i_eos) ? '0 : n_chunk;
            r_ccnt  <= (chunk_done || i_eos) ? '0 : ccnt_inc[CLEN_W-1:0];
            r_bcnt  <= o_block_done ? '0 : bcnt_inc[BLEN_W-1:0];
            r_delta <= i_eos ? '0 : n_delta;
            r_total <= i_eos ? '0 : n_total;
        end
    end

    assign pend_rest = r_pend & (r_pend - 1'b1);
    assign o_valid   = |r_pend;
    assign fire      = o_valid && i_ready;
    assign o_free    = (pend_rest == '0) && (!o_valid || i_ready);

    always_comb begin
        n_pend               = '0;
        n_pend[SLOT_CHUNK]   = chunk_done;
        n_pend[SLOT_BLOCK0]  = o_block_done;
        n_pend[SLOT_BLOCK1]  = o_block_done && i_cfg.stereo;
        n_pend[SLOT_SUMMARY] = i_eos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_adv) begin
            r_pend <= n_pend;
        end else if (fire) begin
            r_pend <= pend_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_chunk <= n_chunk;
            r_b_stat0 <= i_stat0;
            r_b_stat1 <= i_stat1;
            r_b_fib   <= bcnt_inc[BLEN_W-1:0];
            r_b_delta <= n_delta;
            r_b_total <= n_total;
        end
    end

    always_comb begin
        o_result      = '0;
        o_result.last = (pend_rest == '0);
        if (r_pend[SLOT_CHUNK]) begin
            o_result.kind      = KIND_CHUNK;
            o_result.chunk_sum = r_b_chunk;
        end else if (r_pend[SLOT_BLOCK0]) begin
            o_result.kind            = KIND_BLOCK;
            o_result.peak            = r_b_stat0.peak;
            o_result.energy          = r_b_stat0.energy;
            o_result.frames_in_block = r_b_fib;
        end else if (r_pend[SLOT_BLOCK1]) begin
            o_result.kind            = KIND_BLOCK;
            o_result.channel         = 1'b1;
            o_result.peak            = r_b_stat1.peak;
            o_result.energy          = r_b_stat1.energy;
            o_result.frames_in_block = r_b_fib;
        end else begin
            o_result.kind         = KIND_SUMMARY;
            o_result.delta_sum    = r_b_delta;
            o_result.total_frames = r_b_total;
        end
    end

endmodule

/* rtl/core/audio_block_peak_energy_meter.sv */
// Channel   Role    Handshake        Payload
// i_frame   sink    valid/ready      sample_ch0, sample_ch1, end_of_stream
// o_result  source  valid/ready      kind, channel, sums, peak, energy, counts, last
// apb       slave   psel/penable     num_channels @0x0, chunk_length @0x4, block_length @0x8
//
// One frame per cycle while the merge stage is free; a frame passes the lane stage register into
// the result register. A frame ending a chunk, block or stream holds the merge stage until its
// results drain, one per cycle while o_result.ready is high (up to four), with input stalled meanwhile.
// Synchronous active-low reset clears all accumulators and pending results.
// Output stall backs up through the result register into the lane stage and i_frame.ready.
module audio_block_peak_energy_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    abm_frame_if.sink                     i_frame,
    abm_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abm_pkg::PADDR_W-1:0]   paddr,
    input  logic [abm_pkg::PDATA_W-1:0]   pwdata,
    output logic [abm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import abm_pkg::*;

    logic [NCH_W-1:0]  r_num_channels;
    logic [CLEN_W-1:0] r_chunk_length;
    logic [BLEN_W-1:0] r_block_length;
    logic              r_s1_valid;
    logic              r_s1_eos;

    t_cfg              cfg;
    t_lane_ctl         ctl0;
    t_lane_ctl         ctl1;
    t_lane_stat        stat0;
    t_lane_stat        stat1;
    t_result           res;
    logic [LEVEL_W-1:0] level0;
    logic [LEVEL_W-1:0] level1;
    logic              cfg_wr;
    logic              s1_load;
    logic              s2_adv;
    logic              merge_free;
    logic              block_done;
    logic              res_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= NCH_RESET;
            r_chunk_length <= CLEN_RESET;
            r_block_length <= BLEN_RESET;
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1:2])
                REG_NUM_CHANNELS: r_num_channels <= pwdata[NCH_W-1:0];
                REG_CHUNK_LENGTH: r_chunk_length <= pwdata[CLEN_W-1:0];
                REG_BLOCK_LENGTH: r_block_length <= pwdata[BLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_NUM_CHANNELS: prdata = PDATA_W'(r_num_channels);
            REG_CHUNK_LENGTH: prdata = PDATA_W'(r_chunk_length);
            REG_BLOCK_LENGTH: prdata = PDATA_W'(r_block_length);
            default:          prdata = '0;
        endcase
    end

    assign cfg.stereo = (r_num_channels == NCH_STEREO);
    assign cfg.clen   = (r_chunk_length == '0) ? CLEN_W'(1) : r_chunk_length;
    assign cfg.blen   = (r_block_length == '0) ? BLEN_W'(1) : r_block_length;

    assign s2_adv        = r_s1_valid && merge_free;
    assign i_frame.ready = !r_s1_valid || s2_adv;
    assign s1_load       = i_frame.valid && i_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_eos <= i_frame.end_of_stream;
        end
    end

    assign ctl0.load     = s1_load;
    assign ctl0.adv      = s2_adv;
    assign ctl0.use_lane = 1'b1;
    assign ctl0.clear    = block_done;
    assign ctl1.load     = s1_load;
    assign ctl1.adv      = s2_adv;
    assign ctl1.use_lane = cfg.stereo;
    assign ctl1.clear    = r_s1_eos || (cfg.stereo && block_done);

    abm_lane u_lane0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_frame.sample_ch0),
        .i_ctl    (ctl0),
        .o_level  (level0),
        .o_stat   (stat0)
    );

    abm_lane u_lane1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_frame.sample_ch1),
        .i_ctl    (ctl1),
        .o_level  (level1),
        .o_stat   (stat1)
    );

    abm_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_sample0    (i_frame.sample_ch0),
        .i_sample1    (i_frame.sample_ch1),
        .i_load       (s1_load),
        .i_adv        (s2_adv),
        .i_eos        (r_s1_eos),
        .i_level0     (level0),
        .i_level1     (level1),
        .i_stat0      (stat0),
        .i_stat1      (stat1),
        .i_ready      (o_result.ready),
        .o_block_done (block_done),
        .o_free       (merge_free),
        .o_valid      (res_valid),
        .o_result     (res)
    );

    assign o_result.valid           = res_valid;
    assign o_result.kind            = res.kind;
    assign o_result.channel         = res.channel;
    assign o_result.chunk_sum       = res.chunk_sum;
    assign o_result.peak            = res.peak;
    assign o_result.energy          = res.energy;
    assign o_result.frames_in_block = res.frames_in_block;
    assign o_result.delta_sum       = res.delta_sum;
    assign o_result.total_frames    = res.total_frames;
    assign o_result.last            = res.last;

`ifndef NO_ASSERTIONS
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.kind == KIND_SUMMARY) |-> res.last)
        else $error("summary result is not the last of its frame");

    a_mono_no_ch1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.kind == KIND_BLOCK && res.channel) |-> cfg.stereo)
        else $error("channel 1 block stats emitted in mono");

    a_drain_then_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && o_result.ready && res.last) |=> (!res_valid || $past(s2_adv)))
        else $error("results appeared without a merge advance");
`endif

endmodule

/* sim/abm_checker.sv */
module abm_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    abm_frame_if                         i_frame,
    abm_result_if                        i_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [abm_pkg::PADDR_W-1:0]  paddr,
    input  logic [abm_pkg::PDATA_W-1:0]  pwdata,
    input  logic                         pready,
    output int                           o_errors,
    output int                           o_pending
);
    import abm_pkg::*;

    localparam logic [63:0] CHUNK_MAX  = (64'd1 << CHUNK_W) - 64'd1;
    localparam logic [63:0] ENERGY_MAX = (64'd1 << ENERGY_W) - 64'd1;
    localparam logic [63:0] DELTA_MAX  = (64'd1 << DELTA_W) - 64'd1;
    localparam logic [63:0] TOTAL_MAX  = (64'd1 << TOTAL_W) - 64'd1;
    localparam int          PRINT_LIMIT = 100;

    logic [NCH_W-1:0]    cfg_nch;
    logic [CLEN_W-1:0]   cfg_clen;
    logic [BLEN_W-1:0]   cfg_blen;

    logic [CHUNK_W-1:0]  chunk_acc;
    logic [CLEN_W-1:0]   chunk_frames;
    logic [LEVEL_W-1:0]  blk_peak [NUM_LANES];
    logic [ENERGY_W-1:0] blk_energy [NUM_LANES];
    logic [BLEN_W-1:0]   blk_frames;
    logic [DELTA_W-1:0]  diff_acc;
    logic [TOTAL_W-1:0]  stream_frames;

    t_result             meter_results_q [$];
    t_result             oldest;
    int                  error_count = 0;
    int                  pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] max);
        if (a >= max || b > max - a) begin
            return max;
        end
        return a + b;
    endfunction

    task automatic clear_stream();
        chunk_acc     = '0;
        chunk_frames  = '0;
        blk_frames    = '0;
        diff_acc      = '0;
        stream_frames = '0;
        for (int c = 0; c < NUM_LANES; c++) begin
            blk_peak[c]   = '0;
            blk_energy[c] = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch: %s", msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic predict_frame(input logic [LEVEL_W-1:0] s0, input logic [LEVEL_W-1:0] s1,
                                 input logic eos);
        logic        stereo;
        int          v0;
        int          v1;
        int          d;
        int          nch;
        int          n;
        logic [63:0] mag [NUM_LANES];
        logic [63:0] clen;
        logic [63:0] blen;
        t_result     r;

        stereo = (cfg_nch == NCH_STEREO);
        nch    = stereo ? 2 : 1;
        n      = 0;
        v0     = 2 * int'($signed(s0)) + 1;
        v1     = 2 * int'($signed(s1)) + 1;
        mag[0] = (v0 < 0) ? 64'(-v0) : 64'(v0);
        mag[1] = (v1 < 0) ? 64'(-v1) : 64'(v1);
        clen   = (cfg_clen == '0) ? 64'd1 : 64'(cfg_clen);
        blen   = (cfg_blen == '0) ? 64'd1 : 64'(cfg_blen);

        chunk_acc    = CHUNK_W'(sat_add(chunk_acc, mag[0] + (stereo ? mag[1] : 64'd0), CHUNK_MAX));
        chunk_frames = chunk_frames + 1'b1;
        if (64'(chunk_frames) >= clen) begin
            r           = '0;
            r.kind      = KIND_CHUNK;
            r.chunk_sum = chunk_acc;
            meter_results_q = {meter_results_q, r};
            n++;
            chunk_acc    = '0;
            chunk_frames = '0;
        end

        for (int c = 0; c < nch; c++) begin
            if (mag[c] > 64'(blk_peak[c])) begin
                blk_peak[c] = LEVEL_W'(mag[c]);
            end
            blk_energy[c] = ENERGY_W'(sat_add(blk_energy[c], mag[c] * mag[c], ENERGY_MAX));
        end
        blk_frames = blk_frames + 1'b1;
        if (64'(blk_frames) >= blen || eos) begin
            for (int c = 0; c < nch; c++) begin
                r                 = '0;
                r.kind            = KIND_BLOCK;
                r.channel         = c[0];
                r.peak            = blk_peak[c];
                r.energy          = blk_energy[c];
                r.frames_in_block = blk_frames;
                meter_results_q = {meter_results_q, r};
                n++;
                blk_peak[c]   = '0;
                blk_energy[c] = '0;
            end
            blk_frames = '0;
        end

        if (stereo) begin
            d        = v0 - v1;
            diff_acc = DELTA_W'(sat_add(diff_acc, (d < 0) ? 64'(-d) : 64'(d), DELTA_MAX));
        end
        stream_frames = TOTAL_W'(sat_add(stream_frames, 64'd1, TOTAL_MAX));

        if (eos) begin
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.delta_sum    = diff_acc;
            r.total_frames = stream_frames;
            meter_results_q = {meter_results_q, r};
            n++;
            clear_stream();
        end

        if (n > 0) begin
            meter_results_q[meter_results_q.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_nch  = NCH_RESET;
            cfg_clen = CLEN_RESET;
            cfg_blen = BLEN_RESET;
            clear_stream();
            meter_results_q.delete();
            pending_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_NUM_CHANNELS: cfg_nch  = pwdata[NCH_W-1:0];
                    REG_CHUNK_LENGTH: cfg_clen = pwdata[CLEN_W-1:0];
                    REG_BLOCK_LENGTH: cfg_blen = pwdata[BLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (meter_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result of kind %0d", i_result.kind));
                end else begin
                    oldest = meter_results_q.pop_front();
                    check_field("kind", 64'(i_result.kind), 64'(oldest.kind));
                    check_field("channel", 64'(i_result.channel), 64'(oldest.channel));
                    check_field("chunk_sum", 64'(i_result.chunk_sum), 64'(oldest.chunk_sum));
                    check_field("peak", 64'(i_result.peak), 64'(oldest.peak));
                    check_field("energy", 64'(i_result.energy), 64'(oldest.energy));
                    check_field("frames_in_block", 64'(i_result.frames_in_block),
                                64'(oldest.frames_in_block));
                    check_field("delta_sum", 64'(i_result.delta_sum), 64'(oldest.delta_sum));
                    check_field("total_frames", 64'(i_result.total_frames),
                                64'(oldest.total_frames));
                    check_field("last", 64'(i_result.last), 64'(oldest.last));
                end
            end
            if (i_frame.valid && i_frame.ready) begin
                predict_frame(i_frame.sample_ch0, i_frame.sample_ch1, i_frame.end_of_stream);
            end
            pending_count <= meter_results_q.size();
        end
    end

endmodule

/* sim/tb_audio_block_peak_energy_meter.sv */
module tb_audio_block_peak_energy_meter;
    import abm_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_FRAMES  = 400;
    localparam int HOLD_PHASE     = 3;

    localparam logic [NCH_W-1:0] NCH_MONO_ZERO = 2'd0;
    localparam logic [NCH_W-1:0] NCH_MONO      = 2'd1;
    localparam logic [NCH_W-1:0] NCH_MONO_ODD  = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  error_count;
    int                  pending_count;
    int                  idle_cycles = 0;
    bit                  calm = 1'b0;
    bit                  hold_req = 1'b0;
    bit                  hold_done = 1'b0;

    abm_frame_if  frame_ch ();
    abm_result_if result_ch ();

    always #(HALF_PERIOD) i_clk = ~i_clk;

    audio_block_peak_energy_meter i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    abm_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (frame_ch),
        .i_result  (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_audio_block_peak_energy_meter failed");
            $finish;
        end
    end

    // result sink: random backpressure, one long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_req && !hold_done) begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (calm || $urandom_range(1, 0) == 1) begin
                result_ch.ready <= 1'b1;
                n = $urandom_range(14, 1);
                repeat (n) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b0;
                n = $urandom_range(14, 1);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic logic [LEVEL_W-1:0] pick_sample();
        case ($urandom_range(7, 0))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic [LEVEL_W-1:0] s0, input logic [LEVEL_W-1:0] s1,
                              input logic eos);
        int gap;
        if (!calm && $urandom_range(3, 0) == 0) begin
            frame_ch.valid <= 1'b0;
            gap = $urandom_range(14, 1);
            repeat (gap) @(posedge i_clk);
        end
        frame_ch.valid         <= 1'b1;
        frame_ch.sample_ch0    <= s0;
        frame_ch.sample_ch1    <= s1;
        frame_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!frame_ch.ready);
    endtask

    task automatic wait_idle();
        frame_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [NCH_W-1:0] nch, input logic [CLEN_W-1:0] clen,
                             input logic [BLEN_W-1:0] blen);
        wait_idle();
        write_reg(REG_NUM_CHANNELS, PDATA_W'(nch));
        write_reg(REG_CHUNK_LENGTH, PDATA_W'(clen));
        write_reg(REG_BLOCK_LENGTH, PDATA_W'(blen));
    endtask

    task automatic send_stream(input int frames, input bit with_eos);
        for (int i = 0; i < frames; i++) begin
            send_frame(pick_sample(), pick_sample(), with_eos && (i == frames - 1));
        end
    endtask

    initial begin
        int                 sent;
        int                 phase;
        int                 n;
        logic [NCH_W-1:0]   nch;
        logic [CLEN_W-1:0]  clen;
        logic [BLEN_W-1:0]  blen;

        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        frame_ch.valid         <= 1'b0;
        frame_ch.sample_ch0    <= '0;
        frame_ch.sample_ch1    <= '0;
        frame_ch.end_of_stream <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h0000, 16'hFFFF, 1'b1);

        configure(NCH_STEREO, 16'd1, 20'd1);
        send_frame(16'h8000, 16'h8000, 1'b0);
        send_frame(16'h7FFF, 16'h7FFF, 1'b0);
        send_frame(16'h0000, 16'hFFFF, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b0);
        send_frame(16'h1234, 16'hEDCB, 1'b1);

        configure(NCH_MONO_ZERO, 16'd0, 20'd0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h7FFF, 16'h8000, 1'b1);

        configure(NCH_MONO, 16'd3, 20'd2);
        send_frame(16'hFFFF, 16'h5555, 1'b0);
        send_frame(16'h8000, 16'hAAAA, 1'b0);
        send_frame(16'h0001, 16'h8000, 1'b1);

        configure(NCH_MONO_ODD, 16'd1, 20'd5);
        send_frame(16'h4000, 16'hC000, 1'b0);
        send_frame(16'hC000, 16'h4000, 1'b1);

        // shorten lengths in the middle of a stream
        configure(NCH_STEREO, 16'd10, 20'd10);
        send_stream(6, 1'b0);
        configure(NCH_STEREO, 16'd2, 20'd3);
        send_stream(2, 1'b1);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_FRAMES) begin
            if ($urandom_range(1, 0) == 1) begin
                nch = NCH_STEREO;
            end else begin
                nch = NCH_W'($urandom_range(3, 0));
            end
            case ($urandom_range(9, 0))
                0: clen = '0;
                1: clen = '1;
                2: clen = CLEN_W'($urandom_range(300, 17));
                default: clen = CLEN_W'($urandom_range(16, 1));
            endcase
            case ($urandom_range(9, 0))
                0: blen = '0;
                1: blen = '1;
                2: blen = BLEN_W'($urandom_range(500, 25));
                default: blen = BLEN_W'($urandom_range(24, 1));
            endcase
            n = $urandom_range(40, 4);
            if (phase == HOLD_PHASE) begin
                nch  = NCH_STEREO;
                clen = 16'd1;
                blen = 20'd1;
                n    = 40;
            end
            if (sent >= RANDOM_FRAMES * 3 / 4) begin
                calm = 1'b1;
            end
            configure(nch, clen, blen);
            if (phase == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            send_stream(n, $urandom_range(7, 0) != 0);
            sent  += n;
            phase++;
        end

        wait_idle();
        if (error_count == 0) begin
            $display("tb_audio_block_peak_energy_meter passed");
        end else begin
            $display("tb_audio_block_peak_energy_meter failed");
        end
        $finish;
    end

endmodule
